FILE: design/frame_tagged_ring_allocator_core_macros.svh
// Assertion macros of the ring allocator RTL.
// Included by ftra_dp, which carries the concurrent assertions; no other dependency.
`ifndef FRAME_TAGGED_RING_ALLOCATOR_CORE_MACROS_SVH
`define FRAME_TAGGED_RING_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset
`define FTRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ring allocator assertion failed");
// Expression must never be true outside reset
`define FTRA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ring allocator forbidden condition seen");
`else
`define FTRA_ASSERT(lbl, clk, rst_n, prop)
`define FTRA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: design/ftra_pkg.sv
// Shared types, codes, reset values and helper functions of the ring allocator.
// No dependencies; used by ftra_ctrl, ftra_dp and the top level.
package ftra_pkg;

  // Default depth of the range table
  localparam int unsigned RANGE_SLOTS_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_RING_SIZE_LOG2   = 2'd0;
  localparam logic [1:0] CFG_FRAMES_IN_FLIGHT = 2'd1;
  localparam logic [1:0] CFG_BASE_ADDRESS     = 2'd2;

  // Configuration reset values
  localparam logic [4:0]  RING_SIZE_LOG2_RST = 5'd16;
  localparam logic [4:0]  RING_LOG2_MIN      = 5'd4;
  localparam logic [7:0]  FRAMES_IN_FLIGHT_RST = 8'd2;
  localparam logic [63:0] BASE_ADDRESS_RST   = 64'd0;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_GRANTED    = 2'd0,
    STATUS_NO_SPACE   = 2'd1,
    STATUS_TABLE_FULL = 2'd2
  } alloc_status_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RET_RD,
    ST_RET_CHK,
    ST_SPAN,
    ST_DECIDE,
    ST_ALIGN,
    ST_WRAP,
    ST_FIX,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic retire;
    logic span;
    logic decide;
    logic align;
    logic wrap;
    logic fix;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic retire;
    logic fail;
    logic wrap;
    logic out_free;
  } sts_t;

  // Ring offset mask from the size register; sizes below 16 bytes act as 16
  function automatic logic [30:0] ring_mask_f(input logic [4:0] lg);
    logic [4:0]  eff;
    logic [31:0] full;
    eff  = (lg < RING_LOG2_MIN) ? RING_LOG2_MIN : lg;
    full = (32'd1 << eff) - 32'd1;
    return full[30:0];
  endfunction

  // Low-bit mask of a power-of-two alignment
  function automatic logic [31:0] align_mask_f(input logic [4:0] lg);
    return (32'd1 << lg) - 32'd1;
  endfunction

endpackage

FILE: design/ftra_ctrl.sv
// Sequencing state machine of the ring allocator.
// Depends on ftra_pkg for state, command and status types.
module ftra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ftra_pkg::sts_t sts_i,
  output ftra_pkg::cmd_t cmd_o
);

  ftra_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftra_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ftra_pkg::ST_RET_RD;
      end
      ftra_pkg::ST_RET_RD:  state_d = ftra_pkg::ST_RET_CHK;
      ftra_pkg::ST_RET_CHK: begin
        state_d = sts_i.retire ? ftra_pkg::ST_RET_RD : ftra_pkg::ST_SPAN;
      end
      ftra_pkg::ST_SPAN:    state_d = ftra_pkg::ST_DECIDE;
      ftra_pkg::ST_DECIDE: begin
        state_d = sts_i.fail ? ftra_pkg::ST_EMIT : ftra_pkg::ST_ALIGN;
      end
      ftra_pkg::ST_ALIGN:   state_d = ftra_pkg::ST_WRAP;
      ftra_pkg::ST_WRAP: begin
        state_d = sts_i.wrap ? ftra_pkg::ST_FIX : ftra_pkg::ST_EMIT;
      end
      ftra_pkg::ST_FIX:     state_d = ftra_pkg::ST_EMIT;
      ftra_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = ftra_pkg::ST_IDLE;
      end
      default:              state_d = ftra_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ftra_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ftra_pkg::ST_RET_RD:  ;
      ftra_pkg::ST_RET_CHK: cmd_o.retire = sts_i.retire;
      ftra_pkg::ST_SPAN:    cmd_o.span   = 1'b1;
      ftra_pkg::ST_DECIDE:  cmd_o.decide = 1'b1;
      ftra_pkg::ST_ALIGN:   cmd_o.align  = 1'b1;
      ftra_pkg::ST_WRAP:    cmd_o.wrap   = 1'b1;
      ftra_pkg::ST_FIX:     cmd_o.fix    = 1'b1;
      ftra_pkg::ST_EMIT:    cmd_o.emit   = sts_i.out_free;
      default:              ;
    endcase
  end

endmodule

FILE: design/ftra_dp.sv
// Datapath of the ring allocator: configuration, range tables, offset math, result register.
// Depends on ftra_pkg and the assertion macro header.
`include "frame_tagged_ring_allocator_core_macros.svh"

module ftra_dp #(
  parameter int unsigned RangeSlots = ftra_pkg::RANGE_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration writes
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i,
  // request payload
  input  logic [63:0]    frame_index_i,
  input  logic [31:0]    request_size_i,
  input  logic [4:0]     alignment_log2_i,
  // result channel
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic [63:0]    device_address_o,
  output logic [30:0]    ring_offset_o,
  // controller link
  input  ftra_pkg::cmd_t cmd_i,
  output ftra_pkg::sts_t sts_o
);

  localparam int unsigned SlotW = $clog2(RangeSlots);

  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    return (s == SlotW'(RangeSlots - 1)) ? '0 : s + 1'b1;
  endfunction

  // configuration registers
  logic [30:0] mask_q;
  logic [7:0]  fif_q;
  logic [63:0] base_q;

  // request registers
  logic [63:0] frame_q;
  logic [31:0] size_q;
  logic [31:0] amask_q;

  // ring pointers and entry valid bits
  logic [SlotW-1:0]      head_q, tail_q;
  logic [RangeSlots-1:0] row_vld_q, end_vld_q;

  // range tables
  logic [63:0] tag_mem   [RangeSlots];
  logic [31:0] start_mem [RangeSlots];
  logic [31:0] end_mem   [RangeSlots];

  // registered table reads
  logic [63:0] tag_tail_q, tag_head_q;
  logic [31:0] start_tail_q, end_head_q;
  logic        tag_tail_vq, tag_head_vq, start_tail_vq, end_head_vq;
  logic [63:0] tag_tail, tag_head;
  logic [31:0] start_tail, end_head;

  // working registers
  logic [31:0] span_q;
  logic        match_q;
  logic [31:0] os_q, oe_q;
  ftra_pkg::alloc_status_e status_q;

  // result register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [63:0] out_addr_q;
  logic [30:0] out_offset_q;

  // combinational helpers
  logic [31:0]      m32;
  logic [63:0]      age;
  logic [31:0]      s_m, e_m, above, span_w;
  logic [SlotW-1:0] nh;
  logic             no_space, tbl_full, new_rng;
  logic [31:0]      oe_w;
  logic             wrap_w;
  logic             write_new, write_end;
  logic [30:0]      os_masked;

  assign m32 = {1'b0, mask_q};

  // Mask out entries never written since reset
  assign tag_tail   = tag_tail_vq   ? tag_tail_q   : '0;
  assign tag_head   = tag_head_vq   ? tag_head_q   : '0;
  assign start_tail = start_tail_vq ? start_tail_q : '0;
  assign end_head   = end_head_vq   ? end_head_q   : '0;

  // Retire test on the oldest live range
  assign age = frame_q - tag_tail;

  // Largest contiguous free span between newest end and oldest start
  assign s_m    = start_tail & m32;
  assign e_m    = end_head & m32;
  assign above  = m32 - e_m + 32'd1;
  assign span_w = (s_m > e_m) ? (s_m - e_m) : ((above > s_m) ? above : s_m);

  // Slot decision
  assign nh        = slot_next(head_q);
  assign new_rng   = !match_q;
  assign no_space  = span_q < size_q;
  assign tbl_full  = new_rng && (nh == tail_q);
  assign write_new = cmd_i.decide && !no_space && !tbl_full && new_rng;
  assign write_end = cmd_i.emit && (status_q == ftra_pkg::STATUS_GRANTED);

  // Wrap test at the ring end
  assign oe_w   = os_q + size_q;
  assign wrap_w = (os_q & m32) > (oe_w & m32);

  assign os_masked = os_q[30:0] & mask_q;

  assign sts_o.retire   = (tail_q != head_q) && (age > {56'd0, fif_q});
  assign sts_o.fail     = no_space || tbl_full;
  assign sts_o.wrap     = wrap_w;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= ftra_pkg::ring_mask_f(ftra_pkg::RING_SIZE_LOG2_RST);
      fif_q  <= ftra_pkg::FRAMES_IN_FLIGHT_RST;
      base_q <= ftra_pkg::BASE_ADDRESS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ftra_pkg::CFG_RING_SIZE_LOG2:   mask_q <= ftra_pkg::ring_mask_f(cfg_data_i[4:0]);
        ftra_pkg::CFG_FRAMES_IN_FLIGHT: fif_q  <= cfg_data_i[7:0];
        ftra_pkg::CFG_BASE_ADDRESS:     base_q <= cfg_data_i;
        default:                        ;
      endcase
    end
  end

  // Pointers, valid bits and registered valid reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      row_vld_q     <= '0;
      end_vld_q     <= '0;
      tag_tail_vq   <= 1'b0;
      tag_head_vq   <= 1'b0;
      start_tail_vq <= 1'b0;
      end_head_vq   <= 1'b0;
    end else begin
      tag_tail_vq   <= row_vld_q[tail_q];
      tag_head_vq   <= row_vld_q[head_q];
      start_tail_vq <= row_vld_q[tail_q];
      end_head_vq   <= end_vld_q[head_q];
      if (cmd_i.retire) tail_q <= slot_next(tail_q);
      if (write_new) begin
        head_q        <= nh;
        row_vld_q[nh] <= 1'b1;
        end_vld_q[nh] <= 1'b1;
      end
      if (write_end) end_vld_q[head_q] <= 1'b1;
    end
  end

  // Range tables: one write per table per cycle, registered reads
  always_ff @(posedge clk_i) begin
    if (write_new) begin
      tag_mem[nh]   <= frame_q;
      start_mem[nh] <= end_head;
      end_mem[nh]   <= end_head;
    end else if (write_end) begin
      end_mem[head_q] <= oe_q;
    end
    tag_tail_q   <= tag_mem[tail_q];
    tag_head_q   <= tag_mem[head_q];
    start_tail_q <= start_mem[tail_q];
    end_head_q   <= end_mem[head_q];
  end

  // Request capture and offset arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q  <= frame_index_i;
      size_q   <= request_size_i;
      amask_q  <= ftra_pkg::align_mask_f(alignment_log2_i);
      status_q <= ftra_pkg::STATUS_GRANTED;
    end
    if (cmd_i.span) begin
      span_q  <= span_w;
      match_q <= (tag_head == frame_q);
    end
    if (cmd_i.decide) begin
      os_q <= end_head;
      if (no_space) begin
        status_q <= ftra_pkg::STATUS_NO_SPACE;
      end else if (tbl_full) begin
        status_q <= ftra_pkg::STATUS_TABLE_FULL;
      end
    end
    if (cmd_i.align) os_q <= (os_q + amask_q) & ~amask_q;
    if (cmd_i.wrap) begin
      oe_q <= oe_w;
      if (wrap_w) os_q <= (os_q + m32) & ~m32;
    end
    if (cmd_i.fix) oe_q <= oe_w;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      if (status_q == ftra_pkg::STATUS_GRANTED) begin
        out_addr_q   <= base_q + {33'd0, os_masked};
        out_offset_q <= os_masked;
      end else begin
        out_addr_q   <= '0;
        out_offset_q <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign device_address_o = out_addr_q;
  assign ring_offset_o    = out_offset_q;

  // Checks
  `FTRA_ASSERT(a_offset_in_ring, clk_i, rst_ni, out_valid_q |-> ((out_offset_q & ~mask_q) == '0))
  `FTRA_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_q && (out_status_q != ftra_pkg::STATUS_GRANTED)) |-> ((out_addr_q == '0) && (out_offset_q == '0)))
  `FTRA_ASSERT(a_tail_on_retire, clk_i, rst_ni, !cmd_i.retire |=> $stable(tail_q))
  `FTRA_ASSERT(a_head_one_step, clk_i, rst_ni, (head_q != $past(head_q)) |-> (head_q == slot_next($past(head_q))))
  `FTRA_ASSERT_NEVER(a_retire_at_head, clk_i, rst_ni, cmd_i.retire && (tail_q == head_q))

endmodule

FILE: design/frame_tagged_ring_allocator_core.sv
// Top level of the per-frame ring buffer allocator.
// Depends on ftra_pkg, ftra_ctrl and ftra_dp.
//
// One request is handled at a time. A granted request passes through the
// retire check, span, decide, align and wrap steps before its result is
// emitted; a fix step is added when the offset has to be moved to the next
// ring start, and a refused one goes from decide to emit. Each retired range
// repeats the table read and check: the controller walks the tail one slot at a
// time through the registered read of the range tables. The next request is
// taken as soon as the result sits in the output register, even if it has not
// been collected yet. The range table needs no clearing after reset: per-slot
// valid bits make unwritten slots read as zero. Configuration writes are
// always ready and must only be issued while no request is in progress.
module frame_tagged_ring_allocator_core #(
  parameter int unsigned RangeSlots = ftra_pkg::RANGE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] frame_index_i,
  input  logic [31:0] request_size_i,
  input  logic [4:0]  alignment_log2_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] device_address_o,
  output logic [30:0] ring_offset_o
);

  ftra_pkg::cmd_t cmd;
  ftra_pkg::sts_t sts;

  // Accept register writes at any time
  assign cfg_ready_o = 1'b1;

  ftra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftra_dp #(
    .RangeSlots (RangeSlots)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .frame_index_i    (frame_index_i),
    .request_size_i   (request_size_i),
    .alignment_log2_i (alignment_log2_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .device_address_o (device_address_o),
    .ring_offset_o    (ring_offset_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

FILE: tb/sv/frame_tagged_ring_allocator_core_tb.sv
// Self-checking testbench for frame_tagged_ring_allocator_core.
// Depends on ftra_pkg and the allocator RTL; a built-in predictor of the range
// table supplies the expected grants, which are checked against each result transfer.
`timescale 1ns / 100ps

module frame_tagged_ring_allocator_core_tb;

  localparam int unsigned SLOTS         = ftra_pkg::RANGE_SLOTS_DEF;
  localparam int unsigned PHASE_ITEMS   = 146;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned HOLD_AT       = 500;
  localparam int unsigned HOLD_CYCLES   = 150;

  typedef struct packed {
    logic [63:0] frame;
    logic [31:0] size;
    logic [4:0]  align_lg;
  } alloc_req_t;

  typedef struct packed {
    ftra_pkg::alloc_status_e status;
    logic [63:0]             addr;
    logic [30:0]             offset;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] frame_index_i = '0;
  logic [31:0] request_size_i = '0;
  logic [4:0]  alignment_log2_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [63:0] device_address_o;
  logic [30:0] ring_offset_o;

  // Range table and register copies of the predictor
  logic [63:0] tag_mem   [SLOTS] = '{default: '0};
  logic [31:0] start_mem [SLOTS] = '{default: '0};
  logic [31:0] end_mem   [SLOTS] = '{default: '0};
  int unsigned newest = 0;
  int unsigned oldest = 0;
  logic [4:0]  ring_lg  = ftra_pkg::RING_SIZE_LOG2_RST;
  logic [7:0]  fif_cfg  = ftra_pkg::FRAMES_IN_FLIGHT_RST;
  logic [63:0] base_cfg = ftra_pkg::BASE_ADDRESS_RST;

  alloc_req_t  pending_reqs[$];
  grant_t      pending_grants[$];

  logic        in_fire_q = 1'b0;
  logic        out_fire_q = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned ready_gap = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  frame_tagged_ring_allocator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_index_i    (frame_index_i),
    .request_size_i   (request_size_i),
    .alignment_log2_i (alignment_log2_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .device_address_o (device_address_o),
    .ring_offset_o    (ring_offset_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Retire old ranges, check space, then extend or open a range and place the grant
  function automatic grant_t allocate(alloc_req_t r);
    grant_t      g;
    logic [4:0]  lg;
    logic [31:0] m;
    logic [31:0] al;
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] os;
    logic [31:0] oe;
    logic [32:0] span;
    logic [32:0] above;
    int unsigned nh;
    int unsigned slot;
    g.status = ftra_pkg::STATUS_GRANTED;
    g.addr   = '0;
    g.offset = '0;
    lg = (ring_lg < ftra_pkg::RING_LOG2_MIN) ? ftra_pkg::RING_LOG2_MIN : ring_lg;
    m  = (32'd1 << lg) - 32'd1;
    al = 32'd1 << r.align_lg;

    // age is taken modulo 2^64, so a frame behind a tag looks very old
    while (oldest != newest && (r.frame - tag_mem[oldest]) > {56'd0, fif_cfg})
      oldest = (oldest + 1) % SLOTS;

    s = start_mem[oldest] & m;
    e = end_mem[newest] & m;
    if (s > e) begin
      span = {1'b0, s - e};
    end else begin
      above = {1'b0, m} + 33'd1 - {1'b0, e};
      span  = (above > {1'b0, s}) ? above : {1'b0, s};
    end
    if (span < {1'b0, r.size}) begin
      g.status = ftra_pkg::STATUS_NO_SPACE;
      return g;
    end

    if (tag_mem[newest] == r.frame) begin
      slot = newest;
    end else begin
      nh = (newest + 1) % SLOTS;
      if (nh == oldest) begin
        g.status = ftra_pkg::STATUS_TABLE_FULL;
        return g;
      end
      tag_mem[nh]   = r.frame;
      start_mem[nh] = end_mem[newest];
      end_mem[nh]   = end_mem[newest];
      newest = nh;
      slot   = nh;
    end

    // align, and move to the next ring start when the grant would wrap
    os = (end_mem[slot] + al - 32'd1) & ~(al - 32'd1);
    oe = os + r.size;
    if ((os & m) > (oe & m)) begin
      os = (os + m) & ~m;
      oe = os + r.size;
    end
    end_mem[slot] = oe;
    g.addr   = base_cfg + {32'd0, os & m};
    g.offset = os[30:0] & m[30:0];
    return g;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic add_req(logic [63:0] frame, logic [31:0] size, logic [4:0] align_lg);
    pending_reqs.push_back('{frame: frame, size: size, align_lg: align_lg});
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ftra_pkg::CFG_RING_SIZE_LOG2:   ring_lg = val[4:0];
      ftra_pkg::CFG_FRAMES_IN_FLIGHT: fif_cfg = val[7:0];
      default:                        base_cfg = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [4:0] lg, logic [7:0] fif, logic [63:0] base);
    write_reg(ftra_pkg::CFG_RING_SIZE_LOG2, {59'd0, lg});
    write_reg(ftra_pkg::CFG_FRAMES_IN_FLIGHT, {56'd0, fif});
    write_reg(ftra_pkg::CFG_BASE_ADDRESS, base);
  endtask

  // Wait until every request is sent and every grant collected, then let the block go quiet
  task automatic settle();
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || pending_grants.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly frames that advance slowly with several uploads each, plus jumps and stale frames
  task automatic queue_phase(logic [63:0] first_frame);
    logic [63:0] frame;
    logic [31:0] ring_bytes;
    logic [31:0] size;
    logic [4:0]  align_lg;
    int unsigned pick;
    frame = first_frame;
    ring_bytes = (ring_lg < ftra_pkg::RING_LOG2_MIN) ?
                 (32'd1 << ftra_pkg::RING_LOG2_MIN) : (32'd1 << ring_lg);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      frame = frame + 1;
      else if (pick < 34) frame = frame + $urandom_range(2, 600);
      else if (pick < 37) frame = frame - $urandom_range(1, 400);
      pick = $urandom_range(0, 99);
      if (pick < 8)       size = '0;
      else if (pick < 14) size = $urandom;
      else if (pick < 18) size = ring_bytes - $urandom_range(0, 2);
      else if (pick < 28) size = $urandom_range(0, ring_bytes >> 1);
      else                size = $urandom_range(0, ring_bytes >> 3);
      align_lg = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 5)) :
                                                5'($urandom_range(0, 31));
      add_req(frame, size, align_lg);
    end
  endtask

  // Capture each accepted request and predict its grant
  always @(posedge clk_i) begin
    in_fire_q <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      pending_grants.push_back(allocate('{frame: frame_index_i, size: request_size_i,
                                          align_lg: alignment_log2_i}));
  end

  // Present requests from the queue, with a random gap after each transfer
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire_q) begin
      if (in_fire_q) send_gap = no_idle ? 0 : $urandom_range(0, 3);
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        frame_index_i    <= pending_reqs[0].frame;
        request_size_i   <= pending_reqs[0].size;
        alignment_log2_i <= pending_reqs[0].align_lg;
        void'(pending_reqs.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest predicted grant
  always @(posedge clk_i) begin
    grant_t want;
    out_fire_q <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        report("unexpected result", {62'd0, status_o}, '0);
      end else begin
        want = pending_grants.pop_front();
        if (status_o !== want.status)
          report("status", {62'd0, status_o}, {62'd0, want.status});
        if (device_address_o !== want.addr)
          report("device_address", device_address_o, want.addr);
        if (ring_offset_o !== want.offset)
          report("ring_offset", {33'd0, ring_offset_o}, {33'd0, want.offset});
      end
    end
  end

  // Drive result ready: random stalls per result, and one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (out_fire_q) begin
      ready_gap = no_idle ? 0 : $urandom_range(0, 3);
      if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [4:0]  lg;
    logic [7:0]  fif;
    logic [63:0] base;
    logic [63:0] first_frame;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero size, extend, aligned extend, no space, retire, wrap, stale frame
    add_req(64'd0, 32'd0, 5'd0);
    add_req(64'd0, 32'd100, 5'd0);
    add_req(64'd0, 32'd10, 5'd4);
    add_req(64'd1, 32'hFFFF_FFFF, 5'd31);
    add_req(64'd1, 32'd65000, 5'd0);
    add_req(64'd4, 32'd300, 5'd0);
    add_req(64'd4, 32'd100, 5'd6);
    add_req(64'd2, 32'd0, 5'd0);
    settle();

    // Smallest ring (size below range), widest frame window: fill the table, then a stale frame
    configure(5'd0, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int f = 10; f < 25; f++) add_req(64'(f), 32'd0, 5'd0);
    add_req(64'd0, 32'd5, 5'd2);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    settle();

    // Random phases, each with its own register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lg = 5'd12; fif = 8'd2;   base = {$urandom, $urandom};
                 first_frame = 64'd0; end
        1: begin lg = 5'd31; fif = 8'd255; base = 64'hFFFF_FFFF_FFFF_FFF0;
                 first_frame = {$urandom, $urandom}; end
        2: begin lg = 5'd4;  fif = 8'd0;   base = 64'd0;
                 first_frame = 64'hFFFF_FFFF_FFFF_FF00; end
        3: begin lg = 5'd3;  fif = 8'd15;  base = {$urandom, $urandom};
                 first_frame = 64'd100; end
        4: begin lg = 5'd20; fif = 8'd1;   base = {$urandom, $urandom};
                 first_frame = {$urandom, $urandom}; end
        default: begin lg = 5'd8; fif = 8'd40; base = 64'h8000_0000_0000_0000;
                 first_frame = 64'd5; end
      endcase
      configure(lg, fif, base);
      no_idle = (ph == 3);
      @(posedge clk_i);
      queue_phase(first_frame);
      settle();
    end

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
